// ===== hdl/ltm_pkg.sv =====
// Shared types, constants and helper functions of the lock table manager.
package ltm_pkg;

    localparam int KEY_SLOTS   = 8;
    localparam int QUEUE_DEPTH = 8;
    localparam int SLOT_W      = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 15;
    localparam int ROW_W       = QUEUE_DEPTH * ENTRY_W;
    localparam logic [2:0] MODE_MAX = 3'd6;

    typedef logic [2:0] lmode_t;

    typedef enum logic [1:0] {
        OP_LOCK       = 2'd0,
        OP_UNLOCK     = 2'd1,
        OP_UNLOCK_ALL = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        K_GRANTED        = 4'd0,
        K_QUEUED         = 4'd1,
        K_CONV_PENDING   = 4'd2,
        K_WAITER_GRANTED = 4'd3,
        K_CONV_GRANTED   = 4'd4,
        K_DONE           = 4'd5,
        K_NOT_FOUND      = 4'd6,
        K_TABLE_FULL     = 4'd7,
        K_QUEUE_FULL     = 4'd8
    } kind_t;

    typedef enum logic [4:0] {
        C_NONE, C_CAPTURE, C_SELECT, C_SCAN_START, C_NEXT_SLOT, C_READ, C_LOAD,
        C_LOCK, C_WB, C_SHIFT, C_CONV, C_WSTART, C_WSKIP, C_WGRANT, C_REL_END,
        C_TFULL, C_NOTFOUND, C_DONE, C_FINAL
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_LOOKUP, ST_LOAD, ST_LOCK, ST_WB, ST_FIND,
        ST_CONV, ST_WAKE, ST_REL_END, ST_SCAN, ST_NEXT, ST_DONE, ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        W_END, W_SKIP, W_GRANT
    } wake_t;

    typedef struct packed {
        op_t   op;
        logic  out_free;
        logic  hit_any;
        logic  slot_valid;
        logic  slot_last;
        logic  fg_any;
        logic  conv_any;
        logic  cand_any;
        wake_t wake;
    } stat_t;

    function automatic logic compat(input lmode_t req, input lmode_t held);
        logic [6:0] row;
        row = 7'b0000000;
        case (req)
            3'd0:    row = 7'b1111111;
            3'd1:    row = 7'b0011111;
            3'd2:    row = 7'b0000111;
            3'd3:    row = 7'b0001011;
            3'd4:    row = 7'b0000011;
            3'd5:    row = 7'b0001001;
            3'd6:    row = 7'b0000001;
            default: row = 7'b0000000;
        endcase
        if (held > MODE_MAX)
            return 1'b0;
        return row[held];
    endfunction

    function automatic lmode_t mmax(input lmode_t a, input lmode_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== hdl/ltm_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ltm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/ltm_ctrl.sv =====
// Controller state machine that sequences lookups, queue updates and releases.
module ltm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  ltm_pkg::stat_t stat,
    output ltm_pkg::cmd_t  cmd,
    output logic          in_ready
);
    import ltm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = C_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = C_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.op)
                    OP_LOCK, OP_UNLOCK: state_next = ST_LOOKUP;
                    OP_UNLOCK_ALL:
                    begin
                        cmd        = C_SCAN_START;
                        state_next = ST_SCAN;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_LOOKUP:
            begin
                if (stat.hit_any)
                begin
                    cmd        = C_SELECT;
                    state_next = ST_LOAD;
                end
                else if (stat.out_free)
                begin
                    cmd        = (stat.op == OP_LOCK) ? C_TFULL : C_NOTFOUND;
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                cmd        = C_LOAD;
                state_next = (stat.op == OP_LOCK) ? ST_LOCK : ST_FIND;
            end
            ST_LOCK:
            begin
                if (stat.out_free)
                begin
                    cmd        = C_LOCK;
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                cmd        = C_WB;
                state_next = ST_IDLE;
            end
            ST_FIND:
            begin
                if (stat.fg_any)
                begin
                    cmd        = C_SHIFT;
                    state_next = ST_CONV;
                end
                else if (stat.op != OP_UNLOCK)
                begin
                    state_next = ST_NEXT;
                end
                else if (stat.out_free)
                begin
                    cmd        = C_NOTFOUND;
                    state_next = ST_IDLE;
                end
            end
            ST_CONV:
            begin
                if (!stat.conv_any)
                begin
                    cmd        = C_WSTART;
                    state_next = ST_WAKE;
                end
                else if (!stat.cand_any || stat.out_free)
                begin
                    cmd        = C_CONV;
                    state_next = ST_REL_END;
                end
            end
            ST_WAKE:
            begin
                case (stat.wake)
                    W_SKIP:  cmd = C_WSKIP;
                    W_GRANT:
                    begin
                        if (stat.out_free)
                        begin
                            cmd = C_WGRANT;
                        end
                    end
                    default: state_next = ST_REL_END;
                endcase
            end
            ST_REL_END:
            begin
                cmd        = C_REL_END;
                state_next = (stat.op == OP_UNLOCK) ? ST_DONE : ST_NEXT;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd        = C_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (stat.slot_valid)
                begin
                    cmd        = C_READ;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (stat.slot_last)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    cmd        = C_NEXT_SLOT;
                    state_next = ST_SCAN;
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd        = C_FINAL;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== hdl/ltm_datapath.sv =====
// Datapath: slot tables, queue row buffer, row memory and result register.
module ltm_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  ltm_pkg::cmd_t  cmd,
    output ltm_pkg::stat_t stat,
    input  logic [47:0]    in_data,
    input  logic [1:0]     in_user,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [47:0]    out_data,
    output logic [3:0]     out_user,
    output logic           out_last
);
    import ltm_pkg::*;

    op_t               op_reg;
    logic [31:0]       key_reg;
    logic [7:0]        tx_reg;
    lmode_t            m_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [KEY_SLOTS-1:0] valid_reg;
    logic [KEY_SLOTS-1:0] wait_reg;
    logic [31:0]          key_tab [KEY_SLOTS];
    lmode_t               group_tab [KEY_SLOTS];
    logic [CNT_W-1:0]     cnt_tab [KEY_SLOTS];

    logic [7:0]             b_tx [QUEUE_DEPTH];
    lmode_t                 b_mode [QUEUE_DEPTH];
    lmode_t                 b_conv [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] b_gr;
    logic [CNT_W-1:0]       cnt_w;
    logic [CNT_W-1:0]       idx_reg;
    lmode_t                 g_reg;

    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [31:0] out_key_reg;
    logic [7:0]  out_tx_reg;
    lmode_t      out_mode_reg;
    logic        out_last_reg;

    logic              match_any, free_any, hit_any;
    logic [SLOT_W-1:0] match_idx, free_idx, sel_slot;

    logic [QUEUE_DEPTH-1:0] in_q, hit_oh, fg_oh, cand_oh, shift_m;
    lmode_t                 gmax_excl [QUEUE_DEPTH];
    lmode_t                 gmax_all;
    logic                   h_any, fg_any, cand_any, conv_any, wait_any;
    lmode_t                 h_mode, h_conv, h_excl, c_conv;
    logic                   h_gr;
    logic [7:0]             c_tx;
    logic [QIDX_W-1:0]      wi;
    wake_t                  wake;
    logic                   q_full, grant_new, conv_ok;
    logic [ROW_W-1:0]       row_wr, row_rd;

    logic        emit;
    kind_t       e_kind;
    logic [31:0] e_key;
    logic [7:0]  e_tx;
    lmode_t      e_mode;
    logic        e_last;
    logic        out_free;

    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        for (int s = KEY_SLOTS - 1; s >= 0; s--)
        begin
            if (valid_reg[s] && key_tab[s] == key_reg)
            begin
                match_any = 1'b1;
                match_idx = SLOT_W'(s);
            end
            if (!valid_reg[s] || cnt_tab[s] == '0)
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
        hit_any  = match_any || (op_reg == OP_LOCK && free_any);
        sel_slot = match_any ? match_idx : free_idx;
    end

    always_comb
    begin
        logic fh, ff, fc;
        fh       = 1'b0;
        ff       = 1'b0;
        fc       = 1'b0;
        gmax_all = '0;
        conv_any = 1'b0;
        wait_any = 1'b0;
        h_mode   = '0;
        h_conv   = '0;
        h_excl   = '0;
        h_gr     = 1'b0;
        c_conv   = '0;
        c_tx     = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            in_q[i] = CNT_W'(i) < cnt_w;
            gmax_excl[i] = '0;
            for (int j = 0; j < QUEUE_DEPTH; j++)
            begin
                if (j != i && in_q[i] && CNT_W'(j) < cnt_w && b_gr[j])
                begin
                    gmax_excl[i] = mmax(gmax_excl[i], b_mode[j]);
                end
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (in_q[i] && b_gr[i])
            begin
                gmax_all = mmax(gmax_all, b_mode[i]);
            end
            if (in_q[i] && b_gr[i] && b_conv[i] != '0)
            begin
                conv_any = 1'b1;
            end
            if (in_q[i] && (!b_gr[i] || b_conv[i] != '0))
            begin
                wait_any = 1'b1;
            end
            hit_oh[i]  = in_q[i] && b_tx[i] == tx_reg && !fh;
            fh         = fh || (in_q[i] && b_tx[i] == tx_reg);
            fg_oh[i]   = in_q[i] && b_gr[i] && b_tx[i] == tx_reg && !ff;
            ff         = ff || (in_q[i] && b_gr[i] && b_tx[i] == tx_reg);
            cand_oh[i] = in_q[i] && b_gr[i] && b_conv[i] != '0
                         && compat(b_conv[i], gmax_excl[i]) && !fc;
            fc         = fc || (in_q[i] && b_gr[i] && b_conv[i] != '0
                         && compat(b_conv[i], gmax_excl[i]));
            shift_m[i] = fg_oh[i] || ((i > 0) ? shift_m[(i > 0) ? i - 1 : 0] : 1'b0);
            if (hit_oh[i])
            begin
                h_mode = b_mode[i];
                h_conv = b_conv[i];
                h_excl = gmax_excl[i];
                h_gr   = b_gr[i];
            end
            if (cand_oh[i])
            begin
                c_conv = b_conv[i];
                c_tx   = b_tx[i];
            end
        end
        h_any    = fh;
        fg_any   = ff;
        cand_any = fc;
    end

    assign wi        = idx_reg[QIDX_W-1:0];
    assign q_full    = cnt_w >= CNT_W'(QUEUE_DEPTH);
    assign conv_ok   = compat(m_reg, h_excl);
    assign grant_new = cnt_w == '0
                       || (!wait_reg[slot_reg] && compat(m_reg, group_tab[slot_reg]));

    always_comb
    begin
        if (idx_reg >= cnt_w)
        begin
            wake = W_END;
        end
        else if (b_gr[wi])
        begin
            wake = W_SKIP;
        end
        else if (compat(b_mode[wi], g_reg))
        begin
            wake = W_GRANT;
        end
        else
        begin
            wake = W_END;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.op         = op_reg;
        stat.out_free   = out_free;
        stat.hit_any    = hit_any;
        stat.slot_valid = valid_reg[slot_reg];
        stat.slot_last  = slot_reg == SLOT_W'(KEY_SLOTS - 1);
        stat.fg_any     = fg_any;
        stat.conv_any   = conv_any;
        stat.cand_any   = cand_any;
        stat.wake       = wake;
    end

    always_comb
    begin
        emit   = 1'b1;
        e_kind = K_DONE;
        e_key  = key_reg;
        e_tx   = tx_reg;
        e_mode = '0;
        e_last = 1'b1;
        case (cmd)
            C_TFULL:    e_kind = K_TABLE_FULL;
            C_NOTFOUND: e_kind = K_NOT_FOUND;
            C_DONE:     e_kind = K_DONE;
            C_FINAL:    e_key  = '0;
            C_LOCK:
            begin
                if (h_any)
                begin
                    if (!h_gr)
                    begin
                        e_kind = K_QUEUED;
                        e_mode = h_mode;
                    end
                    else if (h_mode >= m_reg)
                    begin
                        e_kind = K_GRANTED;
                        e_mode = h_mode;
                    end
                    else if (conv_ok)
                    begin
                        e_kind = K_GRANTED;
                        e_mode = m_reg;
                    end
                    else
                    begin
                        e_kind = K_CONV_PENDING;
                        e_mode = h_mode;
                    end
                end
                else if (q_full)
                begin
                    e_kind = K_QUEUE_FULL;
                end
                else
                begin
                    e_kind = grant_new ? K_GRANTED : K_QUEUED;
                    e_mode = m_reg;
                end
            end
            C_CONV:
            begin
                emit   = cand_any;
                e_kind = K_CONV_GRANTED;
                e_key  = key_tab[slot_reg];
                e_tx   = c_tx;
                e_mode = c_conv;
                e_last = 1'b0;
            end
            C_WGRANT:
            begin
                e_kind = K_WAITER_GRANTED;
                e_key  = key_tab[slot_reg];
                e_tx   = b_tx[wi];
                e_mode = b_mode[wi];
                e_last = 1'b0;
            end
            default: emit = 1'b0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            row_wr[i*ENTRY_W +: ENTRY_W] = {b_gr[i], b_conv[i], b_mode[i], b_tx[i]};
        end
    end

    ltm_ram #(
        .WIDTH(ROW_W),
        .DEPTH(KEY_SLOTS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (cmd == C_WB || cmd == C_REL_END),
        .wr_addr (slot_reg),
        .wr_data (row_wr),
        .rd_en   (cmd == C_SELECT || cmd == C_READ),
        .rd_addr ((cmd == C_SELECT) ? sel_slot : slot_reg),
        .rd_data (row_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < KEY_SLOTS; s++)
            begin
                group_tab[s] <= '0;
                cnt_tab[s]   <= '0;
            end
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd)
                C_SELECT:
                begin
                    if (!match_any)
                    begin
                        valid_reg[sel_slot] <= 1'b1;
                        wait_reg[sel_slot]  <= 1'b0;
                        group_tab[sel_slot] <= '0;
                        cnt_tab[sel_slot]   <= '0;
                    end
                end
                C_LOCK:
                begin
                    if (h_any)
                    begin
                        if (h_gr && h_mode < m_reg)
                        begin
                            if (conv_ok)
                            begin
                                group_tab[slot_reg] <= mmax(group_tab[slot_reg], m_reg);
                            end
                            else
                            begin
                                wait_reg[slot_reg] <= 1'b1;
                            end
                        end
                    end
                    else if (!q_full)
                    begin
                        cnt_tab[slot_reg] <= cnt_w + CNT_W'(1);
                        if (grant_new)
                        begin
                            group_tab[slot_reg] <= (cnt_w == '0) ? m_reg
                                                   : mmax(group_tab[slot_reg], m_reg);
                        end
                        else
                        begin
                            wait_reg[slot_reg] <= 1'b1;
                        end
                    end
                end
                C_REL_END:
                begin
                    group_tab[slot_reg] <= g_reg;
                    wait_reg[slot_reg]  <= wait_any;
                    cnt_tab[slot_reg]   <= cnt_w;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg <= e_kind;
            out_key_reg  <= e_key;
            out_tx_reg   <= e_tx;
            out_mode_reg <= e_mode;
            out_last_reg <= e_last;
        end
        case (cmd)
            C_CAPTURE:
            begin
                op_reg  <= op_t'(in_user);
                key_reg <= in_data[31:0];
                tx_reg  <= in_data[39:32];
                m_reg   <= (in_data[42:40] > MODE_MAX) ? MODE_MAX : in_data[42:40];
            end
            C_SELECT:
            begin
                slot_reg <= sel_slot;
                if (!match_any)
                begin
                    key_tab[sel_slot] <= key_reg;
                end
            end
            C_SCAN_START: slot_reg <= '0;
            C_NEXT_SLOT:  slot_reg <= slot_reg + SLOT_W'(1);
            C_LOAD:
            begin
                cnt_w <= cnt_tab[slot_reg];
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    {b_gr[i], b_conv[i], b_mode[i], b_tx[i]} <= row_rd[i*ENTRY_W +: ENTRY_W];
                end
            end
            C_LOCK:
            begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (h_any)
                    begin
                        if (hit_oh[i] && h_gr && h_mode < m_reg)
                        begin
                            if (conv_ok)
                            begin
                                b_mode[i] <= m_reg;
                            end
                            else
                            begin
                                b_conv[i] <= mmax(h_conv, m_reg);
                            end
                        end
                    end
                    else if (!q_full && CNT_W'(i) == cnt_w)
                    begin
                        b_tx[i]   <= tx_reg;
                        b_mode[i] <= m_reg;
                        b_conv[i] <= '0;
                        b_gr[i]   <= grant_new;
                    end
                end
            end
            C_SHIFT:
            begin
                cnt_w <= cnt_w - CNT_W'(1);
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                begin
                    if (shift_m[i])
                    begin
                        b_tx[i]   <= b_tx[i+1];
                        b_mode[i] <= b_mode[i+1];
                        b_conv[i] <= b_conv[i+1];
                        b_gr[i]   <= b_gr[i+1];
                    end
                end
            end
            C_CONV:
            begin
                g_reg <= cand_any ? mmax(gmax_all, c_conv) : gmax_all;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (cand_oh[i])
                    begin
                        b_mode[i] <= b_conv[i];
                        b_conv[i] <= '0;
                    end
                end
            end
            C_WSTART:
            begin
                g_reg   <= gmax_all;
                idx_reg <= '0;
            end
            C_WSKIP: idx_reg <= idx_reg + CNT_W'(1);
            C_WGRANT:
            begin
                b_gr[wi] <= 1'b1;
                g_reg    <= mmax(g_reg, b_mode[wi]);
                idx_reg  <= idx_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {5'b0, out_mode_reg, out_tx_reg, out_key_reg};
    assign out_user  = out_kind_reg;
    assign out_last  = out_last_reg;
endmodule

// ===== hdl/lock_table_manager.sv =====
// Top level of the lock table manager: controller plus datapath.
// Each item is a lock, unlock or unlock-all request and yields one or more
// result items, the final one marked by tlast; an item with no operation
// yields none. A lock passes through dispatch, slot lookup, row read, update
// and write-back, and a lock that finds the table full ends after the lookup.
// An unlock releases the entry and then grants a pending conversion or wakes
// waiters, walking the queue; an unlock whose entry is not found ends early.
// An unlock-all dispatches, visits every slot, releases the entries it holds
// in valid slots, and ends with the final done. The pace is set by the single
// row memory that holds every slot's queue and by the walk of one queue entry
// per cycle while results are taken. A result that is not taken stalls the
// block until it is.
module lock_table_manager (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key[31:0], txid[39:32], req_mode[42:40]
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // key_res[31:0], txid_res[39:32], held_mode[42:40]
    output logic [3:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);
    import ltm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ltm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    ltm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );
endmodule

// ===== hdl/ltm_checker.sv =====
// Port-level checks of the lock table manager, bound to the top level.
module ltm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import ltm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new item accepted while one is in work");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tuser != K_WAITER_GRANTED && m_axis_tuser != K_CONV_GRANTED)
        else $error("wake-up result marked last");

    a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == K_DONE || m_axis_tuser == K_NOT_FOUND
            || m_axis_tuser == K_TABLE_FULL || m_axis_tuser == K_QUEUE_FULL)
            |-> m_axis_tdata[42:40] == 3'd0)
        else $error("status result carries a mode");
endmodule

bind lock_table_manager ltm_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Testbench of the lock table manager: directed and random lock traffic checked against a predictor.
module tb_top;
    import ltm_pkg::*;

    typedef struct {
        kind_t  kind;
        logic [31:0] key;
        logic [7:0]  txid;
        lmode_t lmode;
        logic   last;
    } result_t;

    class lock_scoreboard;
        logic        valid [KEY_SLOTS];
        logic [31:0] skey [KEY_SLOTS];
        lmode_t      grp [KEY_SLOTS];
        logic        waitf [KEY_SLOTS];
        int          cnt [KEY_SLOTS];
        logic [7:0]  etx [KEY_SLOTS][QUEUE_DEPTH];
        lmode_t      emode [KEY_SLOTS][QUEUE_DEPTH];
        lmode_t      econv [KEY_SLOTS][QUEUE_DEPTH];
        logic        egnt [KEY_SLOTS][QUEUE_DEPTH];
        result_t     pending_results[$];
        int          errors;

        function new();
            errors = 0;
            for (int s = 0; s < KEY_SLOTS; s++)
            begin
                valid[s] = 0;
                skey[s] = 0;
                grp[s] = 0;
                waitf[s] = 0;
                cnt[s] = 0;
            end
        endfunction

        function bit compatible(int r, int h);
            bit [6:0] row [7];
            row = '{7'h7f, 7'h1f, 7'h07, 7'h0b, 7'h03, 7'h09, 7'h01};
            if (r > 6 || h > 6)
                return 0;
            return row[r][h];
        endfunction

        function void push(kind_t k, logic [31:0] key, logic [7:0] tx, int m);
            result_t r;
            r.kind = k;
            r.key = key;
            r.txid = tx;
            r.lmode = lmode_t'(m);
            r.last = 0;
            pending_results.push_back(r);
        endfunction

        function int others(int s, int skip);
            int g;
            g = 0;
            for (int i = 0; i < cnt[s]; i++)
                if (i != skip && egnt[s][i] && emode[s][i] > g)
                    g = emode[s][i];
            return g;
        endfunction

        function int granted_idx(int s, logic [7:0] tx);
            for (int i = 0; i < cnt[s]; i++)
                if (egnt[s][i] && etx[s][i] == tx)
                    return i;
            return -1;
        endfunction

        function void release_entry(int s, int e);
            int g;
            bit conv;
            bit w;
            conv = 0;
            w = 0;
            for (int i = e; i + 1 < cnt[s]; i++)
            begin
                etx[s][i] = etx[s][i+1];
                emode[s][i] = emode[s][i+1];
                econv[s][i] = econv[s][i+1];
                egnt[s][i] = egnt[s][i+1];
            end
            cnt[s]--;
            g = others(s, -1);
            for (int i = 0; i < cnt[s]; i++)
                if (egnt[s][i] && econv[s][i] != 0)
                    conv = 1;
            if (conv)
            begin
                for (int i = 0; i < cnt[s]; i++)
                    if (egnt[s][i] && econv[s][i] != 0 && compatible(econv[s][i], others(s, i)))
                    begin
                        emode[s][i] = econv[s][i];
                        econv[s][i] = 0;
                        if (emode[s][i] > g)
                            g = emode[s][i];
                        push(K_CONV_GRANTED, skey[s], etx[s][i], emode[s][i]);
                        break;
                    end
            end
            else
            begin
                for (int i = 0; i < cnt[s]; i++)
                begin
                    if (egnt[s][i])
                        continue;
                    if (!compatible(emode[s][i], g))
                        break;
                    egnt[s][i] = 1;
                    if (emode[s][i] > g)
                        g = emode[s][i];
                    push(K_WAITER_GRANTED, skey[s], etx[s][i], emode[s][i]);
                end
            end
            grp[s] = lmode_t'(g);
            for (int i = 0; i < cnt[s]; i++)
                if (!egnt[s][i] || econv[s][i] != 0)
                    w = 1;
            waitf[s] = w;
        endfunction

        function void lock_request(logic [31:0] key, logic [7:0] tx, int m);
            int s;
            int c;
            s = -1;
            for (int i = 0; i < KEY_SLOTS; i++)
                if (valid[i] && skey[i] == key)
                begin
                    s = i;
                    break;
                end
            if (s < 0)
            begin
                for (int i = 0; i < KEY_SLOTS; i++)
                    if (!valid[i] || cnt[i] == 0)
                    begin
                        s = i;
                        break;
                    end
                if (s < 0)
                begin
                    push(K_TABLE_FULL, key, tx, 0);
                    return;
                end
                valid[s] = 1;
                skey[s] = key;
                grp[s] = 0;
                waitf[s] = 0;
                cnt[s] = 0;
            end
            c = cnt[s];
            for (int i = 0; i < c; i++)
            begin
                if (etx[s][i] != tx)
                    continue;
                if (!egnt[s][i])
                    push(K_QUEUED, key, tx, emode[s][i]);
                else if (emode[s][i] >= m)
                    push(K_GRANTED, key, tx, emode[s][i]);
                else if (compatible(m, others(s, i)))
                begin
                    emode[s][i] = lmode_t'(m);
                    if (m > grp[s])
                        grp[s] = lmode_t'(m);
                    push(K_GRANTED, key, tx, m);
                end
                else
                begin
                    if (m > econv[s][i])
                        econv[s][i] = lmode_t'(m);
                    waitf[s] = 1;
                    push(K_CONV_PENDING, key, tx, emode[s][i]);
                end
                return;
            end
            if (c >= QUEUE_DEPTH)
            begin
                push(K_QUEUE_FULL, key, tx, 0);
                return;
            end
            etx[s][c] = tx;
            emode[s][c] = lmode_t'(m);
            econv[s][c] = 0;
            cnt[s] = c + 1;
            if (c == 0 || (!waitf[s] && compatible(m, grp[s])))
            begin
                egnt[s][c] = 1;
                grp[s] = (c == 0 || m > grp[s]) ? lmode_t'(m) : grp[s];
                push(K_GRANTED, key, tx, m);
            end
            else
            begin
                egnt[s][c] = 0;
                waitf[s] = 1;
                push(K_QUEUED, key, tx, m);
            end
        endfunction

        function void note_input(op_t op, logic [31:0] key, logic [7:0] tx, lmode_t lm);
            int m;
            int n0;
            int s;
            int e;
            m = (lm > 6) ? 6 : lm;
            n0 = pending_results.size();
            if (op == OP_LOCK)
                lock_request(key, tx, m);
            else if (op == OP_UNLOCK)
            begin
                e = -1;
                for (s = 0; s < KEY_SLOTS; s++)
                    if (valid[s] && skey[s] == key)
                    begin
                        e = granted_idx(s, tx);
                        break;
                    end
                if (e < 0)
                    push(K_NOT_FOUND, key, tx, 0);
                else
                begin
                    release_entry(s, e);
                    push(K_DONE, key, tx, 0);
                end
            end
            else if (op == OP_UNLOCK_ALL)
            begin
                for (s = 0; s < KEY_SLOTS; s++)
                begin
                    if (!valid[s])
                        continue;
                    e = granted_idx(s, tx);
                    if (e >= 0)
                        release_entry(s, e);
                end
                push(K_DONE, 0, tx, 0);
            end
            if (pending_results.size() > n0)
                pending_results[pending_results.size()-1].last = 1;
        endfunction

        task report(string what, longint got, longint exp);
            $display("mismatch in %s: got %0h, expected %0h", what, got, exp);
            errors++;
        endtask

        task check_result(logic [3:0] k, logic [47:0] d, logic l);
            result_t r;
            if (pending_results.size() == 0)
            begin
                report("unexpected result", k, 0);
                return;
            end
            r = pending_results.pop_front();
            if (k != r.kind)
                report("kind", k, r.kind);
            if (d[31:0] != r.key)
                report("key", d[31:0], r.key);
            if (d[39:32] != r.txid)
                report("txid", d[39:32], r.txid);
            if (d[42:40] != r.lmode)
                report("lock mode", d[42:40], r.lmode);
            if (d[47:43] != 0)
                report("padding", d[47:43], 0);
            if (l != r.last)
                report("last", l, r.last);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    lock_scoreboard lock_sb;
    bit  sink_idle_en;
    bit  src_idle_en;
    bit  hold_go;
    bit  sink_hold;
    logic [31:0] keys [12];

    lock_table_manager dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 0;
        #5;
        clk = 1;
        #5;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    // The receiver holds off for a long stretch once the main sequence asks for it.
    initial
    begin
        sink_hold = 0;
        wait (hold_go);
        @(posedge clk);
        sink_hold <= 1;
        repeat (400) @(posedge clk);
        sink_hold <= 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            lock_sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        if (sink_hold)
            m_axis_tready <= 0;
        else
            m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 25);
    end

    task automatic send_item(op_t op, logic [31:0] key, logic [7:0] tx, logic [2:0] lm);
        while (src_idle_en && $urandom_range(99) < 25)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {5'b0, lm, tx, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        lock_sb.note_input(op, key, tx, lm);
    endtask

    task automatic send_random(bit noisy);
        op_t op;
        int r;
        logic [31:0] key;
        r = $urandom_range(99);
        op = (r < 60) ? OP_LOCK : (r < 85) ? OP_UNLOCK : (r < 95) ? OP_UNLOCK_ALL : OP_NONE;
        key = noisy ? $urandom : keys[$urandom_range(11)];
        send_item(op, key, noisy ? 8'($urandom) : 8'($urandom_range(5)),
                  3'($urandom_range(7)));
    endtask

    initial
    begin
        lock_sb = new();
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        m_axis_tready = 0;
        sink_idle_en = 0;
        src_idle_en = 0;
        hold_go = 0;
        keys[0] = 32'h0;
        keys[1] = 32'hffffffff;
        for (int i = 2; i < 12; i++)
            keys[i] = $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_item(OP_UNLOCK, 32'h0, 8'h0, 3'd0);
        send_item(OP_LOCK, 32'h0, 8'h0, 3'd0);
        send_item(OP_LOCK, 32'hffffffff, 8'hff, 3'd7);
        send_item(OP_LOCK, 32'hffffffff, 8'h01, 3'd1);
        send_item(OP_LOCK, 32'hffffffff, 8'h02, 3'd5);
        send_item(OP_LOCK, 32'hffffffff, 8'h02, 3'd6);
        send_item(OP_LOCK, 32'h0, 8'h01, 3'd2);
        send_item(OP_LOCK, 32'h0, 8'h01, 3'd6);
        send_item(OP_LOCK, 32'h0, 8'h00, 3'd3);
        send_item(OP_LOCK, 32'h0, 8'h00, 3'd1);
        send_item(OP_UNLOCK, 32'h0, 8'h01, 3'd0);
        send_item(OP_UNLOCK, 32'hffffffff, 8'hff, 3'd4);
        send_item(OP_NONE, 32'h1234, 8'h3, 3'd2);
        for (int i = 0; i < 9; i++)
            send_item(OP_LOCK, 32'h100 + i, 8'h10, 3'd4);
        for (int i = 0; i < 9; i++)
            send_item(OP_LOCK, 32'h100, 8'(8'h20 + i), 3'd6);
        send_item(OP_UNLOCK_ALL, 32'h0, 8'h10, 3'd0);
        send_item(OP_UNLOCK_ALL, 32'h0, 8'h77, 3'd0);

        src_idle_en = 1;
        sink_idle_en = 1;
        for (int i = 0; i < 50; i++)
            send_random(i % 8 == 7);
        hold_go = 1;
        for (int i = 0; i < 30; i++)
            send_random(0);
        src_idle_en = 0;
        sink_idle_en = 0;
        for (int i = 0; i < 40; i++)
            send_random(0);
        src_idle_en = 1;
        sink_idle_en = 1;
        for (int i = 0; i < 50; i++)
            send_random(i % 10 == 9);
        s_axis_tvalid <= 0;

        while (lock_sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (lock_sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
